[hdl/btmx_pkg.sv]
// shared types and constants for the binary trie maximum xor block
`default_nettype none
package btmx_pkg;

  localparam int KEY_W = 32;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_value;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] max_xor;
    logic             trie_empty;
    logic             pool_full;
  } out_t;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_LINK,
    S_CHAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic link_wr;
    logic chain_wr;
    logic finish;
    logic res_empty;
    logic res_full;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic pool_empty;
    logic is_query;
    logic miss;
    logic qstop;
    logic last_lvl;
    logic fits;
  } sts_t;

endpackage
`default_nettype wire

[hdl/btmx_ctrl.sv]
// controller state machine sequencing walk, capacity check and node allocation
`default_nettype none
module btmx_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire btmx_pkg::sts_t sts,
  output btmx_pkg::cmd_t      cmd,
  output logic                busy
);

  btmx_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btmx_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != btmx_pkg::S_IDLE);
    case (state_r)
      btmx_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.pool_empty) begin
            if (sts.in_query == btmx_pkg::REQ_QUERY) begin
              cmd.finish    = 1'b1;
              cmd.res_empty = 1'b1;
            end else begin
              // no root yet: skip the walk and go to the capacity check
              state_nxt = btmx_pkg::S_CHECK;
            end
          end else begin
            state_nxt = btmx_pkg::S_WALK;
          end
        end
      end
      btmx_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.is_query) begin
          if (sts.qstop || sts.last_lvl) begin
            cmd.finish = 1'b1;
            state_nxt  = btmx_pkg::S_IDLE;
          end
        end else if (sts.miss) begin
          state_nxt = btmx_pkg::S_CHECK;
        end else if (sts.last_lvl) begin
          // key already stored
          cmd.finish = 1'b1;
          state_nxt  = btmx_pkg::S_IDLE;
        end
      end
      btmx_pkg::S_CHECK: begin
        if (!sts.fits) begin
          cmd.finish   = 1'b1;
          cmd.res_full = 1'b1;
          state_nxt    = btmx_pkg::S_IDLE;
        end else if (sts.pool_empty) begin
          state_nxt = btmx_pkg::S_CHAIN;
        end else begin
          state_nxt = btmx_pkg::S_LINK;
        end
      end
      btmx_pkg::S_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = btmx_pkg::S_CHAIN;
      end
      btmx_pkg::S_CHAIN: begin
        cmd.chain_wr = 1'b1;
        if (sts.last_lvl) begin
          cmd.finish = 1'b1;
          state_nxt  = btmx_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = btmx_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/btmx_dp.sv]
// datapath: node memory, walk registers, allocation pointer and result register
`default_nettype none
module btmx_dp #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire btmx_pkg::in_t   in_data,
  input  wire btmx_pkg::cmd_t  cmd,
  output btmx_pkg::sts_t       sts,
  output logic                 out_valid,
  output btmx_pkg::out_t       out_data
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ENT_W  = 2 * NODE_W;
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(KEY_BITS + 2);
  localparam int SUM_W  = ((CNT_W > LVL_W) ? CNT_W : LVL_W) + 2;

  logic [ENT_W-1:0] mem [NODE_COUNT];
  logic [ENT_W-1:0] rd_data_r;
  logic [NODE_W-1:0] rd_addr;
  logic              we;
  logic [NODE_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic [btmx_pkg::KEY_W-1:0] key_r;
  logic                       qry_r;
  logic [NODE_W-1:0]          node_r;
  logic [LVL_W-1:0]           lvl_r;
  logic [btmx_pkg::KEY_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]           nf_r;
  logic                       out_valid_r;
  btmx_pkg::out_t             out_data_r;

  logic              bit_w, bit_c;
  logic [NODE_W-1:0] lnk_b, lnk_o, next_node;
  logic              take_opp;
  logic [LVL_W-1:0]  lvl_dn;
  logic [SUM_W-1:0]  need_sum;

  function automatic logic key_bit(input logic [btmx_pkg::KEY_W-1:0] k,
                                   input logic [LVL_W-1:0] l);
    logic r;
    r = 1'b0;
    if (32'(l) < 32'(btmx_pkg::KEY_W)) begin
      r = k[5'(l)];
    end
    return r;
  endfunction

  assign lvl_dn   = lvl_r - LVL_W'(1);
  assign bit_w    = key_bit(key_r, lvl_r);
  assign bit_c    = key_bit(key_r, lvl_dn);
  assign lnk_b    = bit_w ? rd_data_r[ENT_W-1:NODE_W] : rd_data_r[NODE_W-1:0];
  assign lnk_o    = bit_w ? rd_data_r[NODE_W-1:0] : rd_data_r[ENT_W-1:NODE_W];
  assign take_opp = qry_r && (lnk_o != '0);
  assign next_node = take_opp ? lnk_o : lnk_b;
  assign need_sum = SUM_W'(nf_r) + SUM_W'(lvl_r) + SUM_W'(1);

  always_comb begin
    best_nxt = best_r;
    if (cmd.walk && take_opp && (32'(lvl_r) < 32'(btmx_pkg::KEY_W))) begin
      best_nxt[5'(lvl_r)] = 1'b1;
    end
  end

  always_comb begin
    sts.in_query   = in_data.req_type;
    sts.pool_empty = (nf_r == '0);
    sts.is_query   = (qry_r == btmx_pkg::REQ_QUERY);
    sts.miss       = (lnk_b == '0);
    sts.qstop      = (next_node == '0);
    sts.last_lvl   = (lvl_r == '0);
    sts.fits       = (need_sum <= SUM_W'(NODE_COUNT));
  end

  // read address is the root on load and follows the walk; otherwise hold the current node entry
  always_comb begin
    if (cmd.load) begin
      rd_addr = '0;
    end else if (cmd.walk) begin
      rd_addr = next_node;
    end else begin
      rd_addr = node_r;
    end
  end

  always_comb begin
    we      = cmd.link_wr || cmd.chain_wr;
    wr_addr = NODE_W'(nf_r);
    wr_data = '0;
    if (cmd.link_wr) begin
      // hook the first new node under the node where the walk stopped
      wr_addr = node_r;
      wr_data = rd_data_r;
      if (bit_w) begin
        wr_data[ENT_W-1:NODE_W] = NODE_W'(nf_r);
      end else begin
        wr_data[NODE_W-1:0] = NODE_W'(nf_r);
      end
    end else if (lvl_r != '0) begin
      if (bit_c) begin
        wr_data[ENT_W-1:NODE_W] = NODE_W'(nf_r) + NODE_W'(1);
      end else begin
        wr_data[NODE_W-1:0] = NODE_W'(nf_r) + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_data.key_value;
      qry_r  <= in_data.req_type;
      node_r <= '0;
      best_r <= '0;
      lvl_r  <= (nf_r == '0) ? LVL_W'(KEY_BITS) : LVL_W'(KEY_BITS - 1);
    end else if (cmd.walk) begin
      best_r <= best_nxt;
      if (qry_r || !sts.miss) begin
        node_r <= next_node;
        lvl_r  <= lvl_dn;
      end
    end else if (cmd.chain_wr) begin
      lvl_r <= lvl_dn;
    end
    out_data_r.max_xor    <= cmd.res_empty ? '0 : best_nxt;
    out_data_r.trie_empty <= cmd.res_empty;
    out_data_r.pool_full  <= cmd.res_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.chain_wr) begin
        nf_r <= nf_r + CNT_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hdl/binary_trie_max_xor.sv]
// top level of the binary trie maximum xor block
//
// An item (insert or query) is taken when start is high and busy is low; each
// item gives one result, shown for one cycle with out_valid, and the receiver
// cannot hold it off. The node memory is read once per cycle with registered
// data, so walks advance one trie level per cycle. A query stays busy while it
// walks and its result shows in the cycle after its last walk step (a query on
// an empty trie answers in the cycle after it is taken and never raises busy).
// An insert that adds nodes walks s levels until it finds a missing link, then
// takes a capacity check, links the new branch and makes one write per new
// node; the walk and the writes together cover each level once, and the very
// first key skips the walk and the link. A duplicate key ends its walk at the
// last level and a dropped insert ends right after the check. The next item can
// be taken in the cycle its predecessor's result is shown. The node memory
// needs no clearing pass: entries are only used after allocation writes them.
`default_nettype none
module binary_trie_max_xor #(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire btmx_pkg::in_t  in_data,
  output logic                out_valid,
  output btmx_pkg::out_t      out_data
);

  btmx_pkg::cmd_t cmd;
  btmx_pkg::sts_t sts;

  btmx_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  btmx_dp #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
